// File: rtl/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared widths, command codes, controller states and the command and status
// bundles that connect the controller to the datapath.
// ----------------------------------------------------------------------------
package rar_pkg;

  // operand and derived widths
  localparam int OperandWidth = 16;
  localparam int ProdWidth    = 2 * OperandWidth;
  localparam int SumWidth     = (2 * OperandWidth + 1 > 64) ? 64 : 2 * OperandWidth + 1;
  localparam int MagWidth     = SumWidth;
  localparam int ShiftWidth   = $clog2(MagWidth + 1);
  localparam int CntWidth     = $clog2(MagWidth);
  localparam int ResNumWidth  = 33;
  localparam int ResDenWidth  = 32;

  // command codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ADD = 2'd0;
  localparam cmd_t CMD_MUL = 2'd1;
  localparam cmd_t CMD_DIV = 2'd2;
  localparam cmd_t CMD_NOP = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_SUM,
    ST_MAG,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mult;
    logic sum;
    logic mag;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic gcd_done;
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

// File: rtl/rational_arith_reduce.sv
// sequence: accept, multiply, sum and magnitude; an error or unused command then goes
// straight to the output hand-off, otherwise a data-dependent binary gcd loop follows
// and a restoring divide loop with one step per quotient bit, SumWidth (33) bits
// flow: one word in flight; the next word is taken while a result waits
// reset: asynchronous active low, returns the sequencer to idle and drops out_valid
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Adds, multiplies or divides two signed fractions and reduces the result by
// the gcd of numerator and denominator magnitudes, keeping signs as formed.
// ----------------------------------------------------------------------------
module rational_arith_reduce
  import rar_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cmd_t                           command_i,
  input  logic signed [OperandWidth-1:0] num_a_i,
  input  logic signed [OperandWidth-1:0] den_a_i,
  input  logic signed [OperandWidth-1:0] num_b_i,
  input  logic signed [OperandWidth-1:0] den_b_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [ResNumWidth-1:0]  res_num_o,
  output logic signed [ResDenWidth-1:0]  res_den_o,
  output logic                           zero_den_error_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencer
  rar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // arithmetic
  rar_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .command_i        (command_i),
    .num_a_i          (num_a_i),
    .den_a_i          (den_a_i),
    .num_b_i          (num_b_i),
    .den_b_i          (den_b_i),
    .cmd_i            (dp_cmd),
    .status_o         (dp_status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .res_num_o        (res_num_o),
    .res_den_o        (res_den_o),
    .zero_den_error_o (zero_den_error_o)
  );

endmodule

// File: rtl/rar_ctrl.sv
// ----------------------------------------------------------------------------
// rar_ctrl
// Sequencer: capture, multiply, sum, magnitude, binary gcd loop, shared
// restoring division loop, then hand-off to the output register.
// ----------------------------------------------------------------------------
module rar_ctrl
  import rar_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = status_i.skip ? ST_FIN : ST_GCD;
      end
      ST_GCD: begin
        if (status_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/rar_dp.sv
// ----------------------------------------------------------------------------
// rar_dp
// Datapath: operand capture, three registered multipliers, cross sum,
// magnitudes, binary gcd, two restoring dividers sharing the gcd as divisor,
// sign restore and the output register.
// ----------------------------------------------------------------------------
module rar_dp
  import rar_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cmd_t                           command_i,
  input  logic signed [OperandWidth-1:0] num_a_i,
  input  logic signed [OperandWidth-1:0] den_a_i,
  input  logic signed [OperandWidth-1:0] num_b_i,
  input  logic signed [OperandWidth-1:0] den_b_i,
  input  dp_cmd_t                        cmd_i,
  output dp_status_t                     status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [ResNumWidth-1:0]  res_num_o,
  output logic signed [ResDenWidth-1:0]  res_den_o,
  output logic                           zero_den_error_o
);

  // captured operands
  cmd_t                           op_q;
  logic signed [OperandWidth-1:0] na_q, da_q, nb_q, db_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= command_i;
      na_q <= num_a_i;
      da_q <= den_a_i;
      nb_q <= num_b_i;
      db_q <= den_b_i;
    end
  end

  // multiplier operand selection
  logic signed [OperandWidth-1:0] m1b, m3b;
  logic signed [ProdWidth-1:0]    p1_d, p2_d, p3_d;
  logic signed [ProdWidth-1:0]    p1_q, p2_q, p3_q;

  always_comb begin
    m1b  = (op_q == CMD_MUL) ? nb_q : db_q;
    m3b  = (op_q == CMD_DIV) ? nb_q : db_q;
    p1_d = na_q * m1b;
    p2_d = nb_q * da_q;
    p3_d = da_q * m3b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
  end

  // raw numerator, denominator and the error and skip flags
  logic signed [SumWidth-1:0]  n_d, n_q;
  logic signed [ProdWidth-1:0] d_q;
  logic                        err_d, err_q, skip_q;

  always_comb begin
    if (op_q == CMD_ADD) begin
      n_d = SumWidth'(p1_q) + SumWidth'(p2_q);
    end else begin
      n_d = SumWidth'(p1_q);
    end
    err_d = (op_q != CMD_NOP) &&
            ((da_q == '0) || (db_q == '0) || (p3_q == '0));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      n_q    <= n_d;
      d_q    <= p3_q;
      err_q  <= err_d;
      skip_q <= err_d || (op_q == CMD_NOP);
    end
  end

  // magnitudes
  logic [MagWidth-1:0]  mn_d, md_d, mn_q, md_q;
  logic [ProdWidth-1:0] dmag;
  logic                 n_neg, d_neg;

  always_comb begin
    n_neg = n_q[SumWidth-1];
    d_neg = d_q[ProdWidth-1];
    mn_d  = n_neg ? MagWidth'(-n_q) : MagWidth'(n_q);
    dmag  = d_neg ? ProdWidth'(-d_q) : ProdWidth'(d_q);
    md_d  = MagWidth'(dmag);
  end

  // binary gcd step
  logic [MagWidth-1:0]   a_q, b_q, a_d, b_d;
  logic [ShiftWidth-1:0] k_q, k_d;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (!a_q[0] && !b_q[0]) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + ShiftWidth'(1);
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_q >= b_q) begin
      a_d = (a_q - b_q) >> 1;
    end else begin
      b_d = (b_q - a_q) >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag) begin
      mn_q <= mn_d;
      md_q <= md_d;
      a_q  <= mn_d;
      b_q  <= md_d;
      k_q  <= '0;
    end else if (cmd_i.gcd_step) begin
      a_q <= a_d;
      b_q <= b_d;
      k_q <= k_d;
    end
  end

  // restoring dividers, both by the gcd
  logic [MagWidth-1:0] g_q, rem_n_q, rem_d_q, quo_n_q, quo_d_q;
  logic [MagWidth-1:0] rem_n_d, rem_d_d;
  logic [MagWidth:0]   tn, td;
  logic                bn, bd;
  logic [CntWidth-1:0] cnt_q;

  always_comb begin
    tn = {rem_n_q, quo_n_q[MagWidth-1]};
    td = {rem_d_q, quo_d_q[MagWidth-1]};
    bn = (tn >= {1'b0, g_q});
    bd = (td >= {1'b0, g_q});
    rem_n_d = bn ? MagWidth'(tn - {1'b0, g_q}) : MagWidth'(tn);
    rem_d_d = bd ? MagWidth'(td - {1'b0, g_q}) : MagWidth'(td);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      g_q     <= (mn_q == '0) ? MagWidth'(1) : ((a_q | b_q) << k_q);
      rem_n_q <= '0;
      rem_d_q <= '0;
      quo_n_q <= mn_q;
      quo_d_q <= md_q;
      cnt_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_n_q <= rem_n_d;
      rem_d_q <= rem_d_d;
      quo_n_q <= {quo_n_q[MagWidth-2:0], bn};
      quo_d_q <= {quo_d_q[MagWidth-2:0], bd};
      cnt_q   <= cnt_q + CntWidth'(1);
    end
  end

  // sign restore
  logic signed [MagWidth-1:0]    rn, rd;
  logic signed [ResNumWidth-1:0] res_num_d;
  logic signed [ResDenWidth-1:0] res_den_d;

  always_comb begin
    rn = $signed(n_neg ? -quo_n_q : quo_n_q);
    rd = $signed(d_neg ? -quo_d_q : quo_d_q);
    if (skip_q) begin
      res_num_d = '0;
      res_den_d = '0;
    end else begin
      res_num_d = ResNumWidth'(rn);
      res_den_d = ResDenWidth'(rd);
    end
  end

  // output register
  logic                          out_valid_q;
  logic signed [ResNumWidth-1:0] res_num_q;
  logic signed [ResDenWidth-1:0] res_den_q;
  logic                          zde_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_num_q <= res_num_d;
      res_den_q <= res_den_d;
      zde_q     <= err_q;
    end
  end

  // status back to the controller
  always_comb begin
    status_o.skip     = skip_q;
    status_o.gcd_done = (a_q == '0) || (b_q == '0);
    status_o.div_done = (cnt_q == CntWidth'(MagWidth - 1));
    status_o.out_full = out_valid_q && !out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign res_num_o        = res_num_q;
  assign res_den_o        = res_den_q;
  assign zero_den_error_o = zde_q;

endmodule

// File: rtl/rar_checker.sv
// ----------------------------------------------------------------------------
// rar_checker
// Port level checks on the reducer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rar_checker
  import rar_pkg::*;
(
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input cmd_t                           command_i,
  input logic signed [OperandWidth-1:0] num_a_i,
  input logic signed [OperandWidth-1:0] den_a_i,
  input logic signed [OperandWidth-1:0] num_b_i,
  input logic signed [OperandWidth-1:0] den_b_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [ResNumWidth-1:0]  res_num_o,
  input logic signed [ResDenWidth-1:0]  res_den_o,
  input logic                           zero_den_error_o
);

  // a waiting input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(command_i) &&
    $stable(num_a_i) && $stable(den_a_i) && $stable(num_b_i) && $stable(den_b_i))
    else $error("waiting input word changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_num_o) &&
    $stable(res_den_o) && $stable(zero_den_error_o))
    else $error("stalled result changed");

  // an error result carries zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_den_error_o |-> res_num_o == '0 && res_den_o == '0)
    else $error("error result with nonzero fields");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // ready only drops on an accept
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("ready dropped without an accept");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed fraction pairs with add, multiply, divide and unused commands
// into rational_arith_reduce, predicts each reduced fraction, and checks every
// result word in order while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import rar_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 200;
  localparam int RandomWords   = 1625;
  localparam int OpMin         = -(2 ** (OperandWidth - 1));
  localparam int OpMax         = 2 ** (OperandWidth - 1) - 1;

  typedef logic signed [OperandWidth-1:0] operand_t;

  // one reduced fraction as the block reports it
  typedef struct packed {
    logic signed [ResNumWidth-1:0] res_num;
    logic signed [ResDenWidth-1:0] res_den;
    logic                          zero_den;
  } fraction_t;

  // shapes of random operands
  typedef enum int {
    OP_FULL,
    OP_SMALL,
    OP_SCALED,
    OP_POW2,
    OP_EDGE
  } operand_shape_e;

  // receiver stall modes
  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_HOLD
  } rx_mode_e;

  logic     clk_i;
  logic     rst_ni           = 1'b0;
  logic     in_valid_i       = 1'b0;
  logic     in_ready_o;
  cmd_t     command_i        = CMD_ADD;
  operand_t num_a_i          = '0;
  operand_t den_a_i          = '0;
  operand_t num_b_i          = '0;
  operand_t den_b_i          = '0;
  logic     out_valid_o;
  logic     out_ready_i      = 1'b0;
  logic signed [ResNumWidth-1:0] res_num_o;
  logic signed [ResDenWidth-1:0] res_den_o;
  logic     zero_den_error_o;

  fraction_t pending_fractions[$];
  int        fail_count  = 0;
  int        burst_left  = 0;
  int        idle_cycles = 0;
  int        rx_left     = 0;
  rx_mode_e  rx_mode     = RX_OPEN;

  rational_arith_reduce uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .num_a_i          (num_a_i),
    .den_a_i          (den_a_i),
    .num_b_i          (num_b_i),
    .den_b_i          (den_b_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .res_num_o        (res_num_o),
    .res_den_o        (res_den_o),
    .zero_den_error_o (zero_den_error_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // multiply out, then divide both parts by the gcd of their magnitudes
  function automatic fraction_t reduce_fraction(input cmd_t cmd,
                                                input operand_t na, da, nb, db);
    longint          a_n, a_d, b_n, b_d, raw_num, raw_den;
    longint unsigned mag_num, mag_den, divisor, x, y, t, q_num, q_den;
    fraction_t       r;
    r   = '0;
    a_n = na;
    a_d = da;
    b_n = nb;
    b_d = db;
    if (cmd == CMD_NOP) return r;
    case (cmd)
      CMD_ADD: begin
        raw_num = a_n * b_d + b_n * a_d;
        raw_den = a_d * b_d;
      end
      CMD_MUL: begin
        raw_num = a_n * b_n;
        raw_den = a_d * b_d;
      end
      default: begin
        raw_num = a_n * b_d;
        raw_den = a_d * b_n;
      end
    endcase
    if (a_d == 0 || b_d == 0 || raw_den == 0) begin
      r.zero_den = 1'b1;
      return r;
    end
    mag_num = (raw_num < 0) ? longint'(-raw_num) : raw_num;
    mag_den = (raw_den < 0) ? longint'(-raw_den) : raw_den;
    if (mag_num == 0) begin
      divisor = 1;
    end else begin
      x = mag_num;
      y = mag_den;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      divisor = (x == 0) ? 1 : x;
    end
    q_num = mag_num / divisor;
    q_den = mag_den / divisor;
    if (raw_num < 0) q_num = -q_num;
    if (raw_den < 0) q_den = -q_den;
    r.res_num = q_num[ResNumWidth-1:0];
    r.res_den = q_den[ResDenWidth-1:0];
    return r;
  endfunction

  // random operand of a given shape; factor is shared by scaled operands
  function automatic operand_t pick_operand(input operand_shape_e shape, input int factor);
    int v;
    case (shape)
      OP_FULL:   v = $urandom;
      OP_SMALL:  v = int'($urandom_range(0, 128)) - 64;
      OP_SCALED: v = (int'($urandom_range(0, 300)) - 150) * factor;
      OP_POW2: begin
        v = int'($urandom_range(1, 15)) << $urandom_range(0, 10);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = OpMin;
          1: v = OpMax;
          2: v = -1;
          3: v = 1;
          4: v = 0;
          default: v = OpMin + 1;
        endcase
      end
    endcase
    return operand_t'(v);
  endfunction

  // send one word in bursts with random gaps, predict it once accepted
  task automatic send_word(input cmd_t cmd, input operand_t na, da, nb, db);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 10);
        default: gap = $urandom_range(11, 110);
      endcase
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    num_a_i    <= na;
    den_a_i    <= da;
    num_b_i    <= nb;
    den_b_i    <= db;
    do @(posedge clk_i); while (!in_ready_o);
    pending_fractions.push_back(reduce_fraction(cmd, na, da, nb, db));
  endtask

  // one ordinary word per command
  task automatic test_each_command();
    send_word(CMD_ADD, 1, 2, 1, 3);
    send_word(CMD_MUL, 6, 35, 14, 9);
    send_word(CMD_DIV, 9, 4, 3, 8);
    send_word(CMD_NOP, 123, 45, -67, 89);
  endtask

  // largest and smallest operands in every position
  task automatic test_field_extremes();
    send_word(CMD_ADD, OpMin, OpMin, OpMin, OpMin);
    send_word(CMD_ADD, OpMax, OpMax, OpMax, OpMax);
    send_word(CMD_ADD, OpMin, OpMax, OpMax, OpMin);
    send_word(CMD_MUL, OpMin, 1, OpMin, 1);
    send_word(CMD_MUL, OpMax, OpMin, OpMin, OpMax);
    send_word(CMD_DIV, OpMin, 1, 1, OpMin);
    send_word(CMD_DIV, OpMax, -1, OpMin, OpMax);
    send_word(CMD_NOP, OpMin, OpMin, OpMax, OpMax);
  endtask

  // zero denominators from either input or from dividing by a zero fraction
  task automatic test_zero_denominator();
    send_word(CMD_ADD, 5, 0, 3, 7);
    send_word(CMD_MUL, 5, 7, 3, 0);
    send_word(CMD_DIV, 5, 0, 3, 0);
    send_word(CMD_ADD, 0, 0, 0, 0);
    send_word(CMD_DIV, 5, 3, 0, 7);
    send_word(CMD_DIV, 0, 3, 0, -7);
    send_word(CMD_NOP, 5, 0, 3, 0);
  endtask

  // signs kept as formed, and zero numerators reduced by one
  task automatic test_sign_and_zero_numerator();
    send_word(CMD_MUL, -3, 4, 2, -6);
    send_word(CMD_ADD, 1, 2, -1, 2);
    send_word(CMD_MUL, 0, -3, 4, 5);
    send_word(CMD_DIV, -8, -12, 6, 9);
  endtask

  // mixed operand shapes, mostly valid denominators, all commands
  task automatic test_random_mix();
    operand_shape_e shape;
    operand_t       na, da, nb, db;
    cmd_t           cmd;
    int             factor;
    int             pick;
    for (int i = 0; i < RandomWords; i++) begin
      factor = $urandom_range(1, 200);
      pick   = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: shape = OP_FULL;
        3, 4:    shape = OP_SMALL;
        5, 6:    shape = OP_SCALED;
        7:       shape = OP_POW2;
        default: shape = OP_EDGE;
      endcase
      if (pick == 9) begin
        // each field its own shape
        na = pick_operand(operand_shape_e'($urandom_range(0, 4)), factor);
        da = pick_operand(operand_shape_e'($urandom_range(0, 4)), factor);
        nb = pick_operand(operand_shape_e'($urandom_range(0, 4)), factor);
        db = pick_operand(operand_shape_e'($urandom_range(0, 4)), factor);
      end else begin
        na = pick_operand(shape, factor);
        da = pick_operand(shape, factor);
        nb = pick_operand(shape, factor);
        db = pick_operand(shape, factor);
      end
      // keep zero denominators rare
      if (da == 0 && $urandom_range(0, 7) != 0) da = 1;
      if (db == 0 && $urandom_range(0, 7) != 0) db = -1;
      pick = $urandom_range(0, 99);
      if (pick < 30)      cmd = CMD_ADD;
      else if (pick < 60) cmd = CMD_MUL;
      else if (pick < 94) cmd = CMD_DIV;
      else                cmd = CMD_NOP;
      send_word(cmd, na, da, nb, db);
    end
  endtask

  // compare each result word with the oldest prediction, then pick next ready
  always @(posedge clk_i) begin : check_and_stall
    fraction_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_fractions.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result word with none pending: num %0d den %0d err %0b",
                   $realtime, res_num_o, res_den_o, zero_den_error_o);
      end else begin
        want = pending_fractions.pop_front();
        if (res_num_o !== want.res_num || res_den_o !== want.res_den ||
            zero_den_error_o !== want.zero_den) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch: expected num %0d den %0d err %0b, got num %0d den %0d err %0b",
                     $realtime, want.res_num, want.res_den, want.zero_den,
                     res_num_o, res_den_o, zero_den_error_o);
        end
      end
    end
    // receiver stall pattern: open, random or held phases, never two holds in a row
    if (rx_left == 0) begin
      if (rx_mode == RX_HOLD) rx_mode = rx_mode_e'($urandom_range(0, 1));
      else rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 150) : $urandom_range(1, 300);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= $urandom_range(0, 1);
      default:   out_ready_i <= 1'b0;
    endcase
  end

  // watchdog on cycles with no accepted word on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_each_command();
    test_field_extremes();
    test_zero_denominator();
    test_sign_and_zero_numerator();
    test_random_mix();
    in_valid_i <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_fractions.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
